// ----- rtl/core/tca_pkg.sv -----
// ----------------------------------------------------------------------------
// tca_pkg
// shared types, constants and byte helpers for the time-of-day counter
// ----------------------------------------------------------------------------
package tca_pkg;

  localparam int unsigned CountWidth = 24;
  localparam int unsigned ByteWidth  = 8;

  typedef logic [CountWidth-1:0] tod_word_t;
  typedef logic [ByteWidth-1:0]  tod_byte_t;

  typedef enum logic [2:0] {
    REQ_TICK        = 3'd0,
    REQ_WRITE_COUNT = 3'd1,
    REQ_WRITE_ALARM = 3'd2,
    REQ_READ_COUNT  = 3'd3,
    REQ_READ_ALARM  = 3'd4,
    REQ_SET_STOP    = 3'd5
  } req_type_t;

  typedef enum logic [1:0] {
    SEL_LOW  = 2'd0,
    SEL_MID  = 2'd1,
    SEL_HIGH = 2'd2
  } byte_sel_t;

  localparam tod_word_t CountReset  = 24'h01_0000;
  localparam tod_word_t AlarmReset  = 24'h00_0000;
  localparam logic [11:0] LowAllOnes = 12'hFFF;

  function automatic tod_word_t put_byte(tod_word_t word, logic [1:0] sel, tod_byte_t b);
    tod_word_t res;
    res = word;
    case (sel)
      SEL_LOW:  res[7:0]   = b;
      SEL_MID:  res[15:8]  = b;
      SEL_HIGH: res[23:16] = b;
      default:  res = word;
    endcase
    return res;
  endfunction

  function automatic tod_byte_t get_byte(tod_word_t word, logic [1:0] sel);
    tod_byte_t res;
    case (sel)
      SEL_LOW:  res = word[7:0];
      SEL_MID:  res = word[15:8];
      SEL_HIGH: res = word[23:16];
      default:  res = '0;
    endcase
    return res;
  endfunction

endpackage

// ----- rtl/core/tca_if.sv -----
// ----------------------------------------------------------------------------
// tca channel interfaces
// valid/ready request and response channels of the time-of-day counter
// ----------------------------------------------------------------------------
interface tca_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [1:0] byte_sel;
  logic [7:0] write_data;

  modport source (output valid, output req_type, output byte_sel, output write_data,
                  input ready);
  modport sink   (input valid, input req_type, input byte_sel, input write_data,
                  output ready);
endinterface

interface tca_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       alarm_irq;

  modport source (output valid, output read_data, output alarm_irq, input ready);
  modport sink   (input valid, input read_data, input alarm_irq, output ready);
endinterface

// ----- rtl/core/tod_counter_alarm_core.sv -----
// ----------------------------------------------------------------------------
// tod_counter_alarm_core
// 24-bit time-of-day counter with byte access and an edge-triggered alarm
//
// req carries one request per transfer: a tick, a counter or alarm byte
// write, a counter or alarm byte read, or a stop flag update. rsp returns
// exactly one result per request: the read byte (zero for non-reads) and
// alarm_irq, set when the counter newly matches the alarm.
// cfg_wr_en/cfg_wr_data write the carry glitch mode bit; when set, a tick
// carrying into bit 12 also compares the partly carried value.
// response valid is registered and rises in the cycle after the request
// transfer. state updates at the transfer, so a request is taken every
// cycle unless rsp stalls; the single response register is the only buffer.
// while rsp is stalled with a result held, req.ready is low; it rises in
// the cycle the held result transfers out.
// reset loads the counter with 0x010000, clears the alarm, marks the match
// as seen, halts the counter, clears the glitch mode and empties rsp.
// ----------------------------------------------------------------------------
module tod_counter_alarm_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  tca_req_if.sink    req,
  tca_rsp_if.source  rsp
);

  tca_pkg::tod_word_t count_value, count_value_next;
  tca_pkg::tod_word_t alarm_value, alarm_value_next;
  logic               match_seen, match_seen_next;
  logic               halted, halted_next;
  logic               carry_glitch_mode;

  logic               res_valid;
  tca_pkg::tod_byte_t res_data, res_data_next;
  logic               res_irq, res_irq_next;

  logic               accept;

  assign req.ready = !res_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign rsp.valid     = res_valid;
  assign rsp.read_data = res_data;
  assign rsp.alarm_irq = res_irq;

  always_comb begin
    tca_pkg::tod_word_t partial;
    tca_pkg::tod_word_t incr;
    logic               eq_partial;
    logic               seen_mid;
    logic               eq_final;

    count_value_next = count_value;
    alarm_value_next = alarm_value;
    match_seen_next  = match_seen;
    halted_next      = halted;
    res_data_next    = '0;
    res_irq_next     = 1'b0;
    partial          = {count_value[23:12], 12'h000};
    incr             = count_value + 24'd1;
    eq_partial       = (partial == alarm_value);
    seen_mid         = match_seen;
    eq_final         = 1'b0;

    case (req.req_type)
      tca_pkg::REQ_TICK: begin
        if (!halted) begin
          if (carry_glitch_mode && count_value[11:0] == tca_pkg::LowAllOnes) begin
            res_irq_next = !match_seen && eq_partial;
            seen_mid     = eq_partial;
          end
          eq_final         = (incr == alarm_value);
          res_irq_next     = res_irq_next || (!seen_mid && eq_final);
          match_seen_next  = eq_final;
          count_value_next = incr;
        end
      end
      tca_pkg::REQ_WRITE_COUNT: begin
        if (req.byte_sel != 2'd3) begin
          count_value_next = tca_pkg::put_byte(count_value, req.byte_sel, req.write_data);
          eq_final         = (count_value_next == alarm_value);
          res_irq_next     = !match_seen && eq_final;
          match_seen_next  = eq_final;
        end
      end
      tca_pkg::REQ_WRITE_ALARM: begin
        if (req.byte_sel != 2'd3) begin
          alarm_value_next = tca_pkg::put_byte(alarm_value, req.byte_sel, req.write_data);
          eq_final         = (count_value == alarm_value_next);
          res_irq_next     = !match_seen && eq_final;
          match_seen_next  = eq_final;
        end
      end
      tca_pkg::REQ_READ_COUNT: res_data_next = tca_pkg::get_byte(count_value, req.byte_sel);
      tca_pkg::REQ_READ_ALARM: res_data_next = tca_pkg::get_byte(alarm_value, req.byte_sel);
      tca_pkg::REQ_SET_STOP:   halted_next   = req.write_data[0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_value <= tca_pkg::CountReset;
      alarm_value <= tca_pkg::AlarmReset;
      match_seen  <= 1'b1;
      halted      <= 1'b1;
    end else if (accept) begin
      count_value <= count_value_next;
      alarm_value <= alarm_value_next;
      match_seen  <= match_seen_next;
      halted      <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry_glitch_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      carry_glitch_mode <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_data <= res_data_next;
      res_irq  <= res_irq_next;
    end
  end

`ifndef NO_ASSERTIONS
  // every accepted request yields a response next cycle
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> res_valid)
    else $error("response missing after request transfer");

  // a held response blocks new requests
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !rsp.ready) |-> !req.ready)
    else $error("request taken while response stalled");

  // ticks while halted leave the counter alone
  a_halt_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && req.req_type == tca_pkg::REQ_TICK && halted) |=> $stable(count_value))
    else $error("counter moved while halted");

  // reads never raise the alarm
  a_read_no_irq: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.req_type == tca_pkg::REQ_READ_COUNT ||
                req.req_type == tca_pkg::REQ_READ_ALARM)) |=> !res_irq)
    else $error("alarm raised by a read");
`endif

endmodule
